// ----- hdl/cslf_pkg.sv -----
// Shared types and constants for the comment-stripping line filter.
// No dependencies; imported by every module of the block.
package cslf_pkg;

	// field widths fixed by the stream format
	localparam int BYTE_W     = 8;
	localparam int KIND_W     = 2;
	localparam int LINE_NUM_W = 24;
	localparam int CFG_IDX_W  = 2;

	// newline byte
	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COMMENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OPEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_CLOSE  = 2'd2;

	// configuration reset values
	localparam logic [BYTE_W-1:0] RST_LINE_COMMENT = 8'd35;
	localparam logic [BYTE_W-1:0] RST_BLOCK_OPEN   = 8'd123;
	localparam logic [BYTE_W-1:0] RST_BLOCK_CLOSE  = 8'd125;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// classified byte word passed from front to back
	typedef struct packed {
		logic              is_eof;
		logic              is_newline;
		logic              is_line_cmt;
		logic              is_open;
		logic              is_close;
		logic [BYTE_W-1:0] data;
	} cslf_op_t;

	// marker bytes currently programmed
	typedef struct packed {
		logic [BYTE_W-1:0] line_cmt;
		logic [BYTE_W-1:0] blk_open;
		logic [BYTE_W-1:0] blk_close;
	} cslf_cfg_t;

endpackage

// ----- hdl/cslf_front.sv -----
// Front end: accepts input words and classifies each byte against the markers.
// Depends on cslf_pkg.
module cslf_front import cslf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cslf_cfg_t         cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              end_of_file,
	output logic              push_valid,
	input  logic              push_ready,
	output cslf_op_t          push_data
);

	logic     valid_s1;
	cslf_op_t op_s1;
	cslf_op_t op_d;
	logic     advance;

	// stage moves when empty or when the queue takes its word
	assign advance  = !valid_s1 || push_ready;
	assign in_stall = !advance;

	// classify the incoming byte; end of file masks all compares
	always_comb begin
		op_d.is_eof      = end_of_file;
		op_d.is_newline  = !end_of_file && (in_byte == NEWLINE_BYTE);
		op_d.is_line_cmt = !end_of_file && (in_byte == cfg.line_cmt);
		op_d.is_open     = !end_of_file && (in_byte == cfg.blk_open);
		op_d.is_close    = !end_of_file && (in_byte == cfg.blk_close);
		op_d.data        = in_byte;
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			op_s1 <= op_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = op_s1;

endmodule

// ----- hdl/cslf_queue.sv -----
// Short queue decoupling the classifier from the comment state machine.
// Depends on cslf_pkg.
module cslf_queue import cslf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  cslf_op_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output cslf_op_t pop_data
);

	cslf_op_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/cslf_back.sv -----
// Back end: comment nesting, line tracking, line counter and output register.
// Depends on cslf_pkg.
module cslf_back import cslf_pkg::*; #(
	parameter int NEST_LIMIT      = 255,
	parameter int LINE_COUNT_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  cslf_op_t              pop_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [KIND_W-1:0]     item_kind,
	output logic [BYTE_W-1:0]     out_char,
	output logic [LINE_NUM_W-1:0] line_number
);

	localparam int DEPTH_W = $clog2(NEST_LIMIT + 1);

	logic [DEPTH_W-1:0]         depth_q, depth_d;
	logic                       skip_q, skip_d;
	logic                       text_q, text_d;
	logic [LINE_COUNT_BITS-1:0] cnt_q, cnt_d;
	logic                       bump;
	logic                       emit;
	logic [KIND_W-1:0]          kind_d;
	logic [BYTE_W-1:0]          char_d;
	logic                       do_pop;
	logic                       in_block;
	logic [LINE_COUNT_BITS+LINE_NUM_W-1:0] cnt_ext;

	logic                       out_valid_q;
	logic [KIND_W-1:0]          kind_q;
	logic [BYTE_W-1:0]          char_q;
	logic [LINE_NUM_W-1:0]      line_q;

	// take a word when the output slot is free or being drained
	assign pop_ready = !out_valid_q || !out_stall;
	assign do_pop    = pop_valid && pop_ready;
	assign in_block  = (depth_q != '0);

	// next state and result for the word at the queue head
	always_comb begin
		depth_d = depth_q;
		skip_d  = skip_q;
		text_d  = text_q;
		bump    = 1'b0;
		emit    = 1'b0;
		kind_d  = KIND_CHAR;
		char_d  = '0;
		priority if (pop_data.is_eof) begin
			bump    = 1'b1;
			depth_d = '0;
			skip_d  = 1'b0;
			text_d  = 1'b0;
			if (in_block) begin
				emit   = 1'b1;
				kind_d = KIND_ERROR;
			end else if (text_q) begin
				emit   = 1'b1;
				kind_d = KIND_LINE;
			end
		end else if (in_block) begin
			bump = pop_data.is_newline;
			if (pop_data.is_close) begin
				depth_d = depth_q - 1'b1;
			end else if (pop_data.is_open && (depth_q < DEPTH_W'(NEST_LIMIT))) begin
				depth_d = depth_q + 1'b1;
			end
		end else if (pop_data.is_newline) begin
			bump   = 1'b1;
			skip_d = 1'b0;
			text_d = 1'b0;
			if (text_q) begin
				emit   = 1'b1;
				kind_d = KIND_LINE;
			end
		end else if (skip_q) begin
			// inside a line comment, drop the byte
		end else if (pop_data.is_line_cmt) begin
			skip_d = 1'b1;
		end else if (pop_data.is_open) begin
			depth_d = DEPTH_W'(1);
		end else if (pop_data.is_close) begin
			// stray close marker, drop it
		end else begin
			text_d = 1'b1;
			emit   = 1'b1;
			char_d = pop_data.data;
		end
		cnt_d = (bump && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;
	end

	// counter value as seen on the result port
	assign cnt_ext = {{LINE_NUM_W{1'b0}}, cnt_d};

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			skip_q  <= 1'b0;
			text_q  <= 1'b0;
			cnt_q   <= '0;
		end else if (do_pop) begin
			depth_q <= depth_d;
			skip_q  <= skip_d;
			text_q  <= text_d;
			cnt_q   <= cnt_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_pop) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (do_pop && emit) begin
			kind_q <= kind_d;
			char_q <= char_d;
			line_q <= cnt_ext[LINE_NUM_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign item_kind   = kind_q;
	assign out_char    = char_q;
	assign line_number = line_q;

endmodule

// ----- hdl/comment_stripping_line_filter_core.sv -----
// Top level of the comment-stripping line filter.
// Depends on cslf_pkg, cslf_front, cslf_queue and cslf_back.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one word per byte: in_byte and
//   end_of_file. Output channel (out_valid/out_stall) carries item_kind,
//   out_char and line_number. A word moves at a clock edge with valid high
//   and stall low. Configuration writes (cfg_valid/cfg_ready, cfg_index,
//   cfg_data) set the line comment, block open and block close markers;
//   cfg_ready is always high and indexes past the last register are dropped.
// Timing:
//   One input word per cycle sustained while out_stall stays low. A result
//   reaches out_valid through the classifier stage and the queue, then the
//   state machine updates depth, line flags and counter as it loads the
//   output register. Dropped bytes give no result. A four-entry queue absorbs
//   short output stalls; once it and the classifier stage are full, in_stall
//   rises.
// Reset:
//   arst_n clears depth, line flags, line counter, queue and output valid
//   and loads the default markers; no clearing pass is needed.
module comment_stripping_line_filter_core import cslf_pkg::*; #(
	parameter int NEST_LIMIT      = 255,
	parameter int LINE_COUNT_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [BYTE_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BYTE_W-1:0]     in_byte,
	input  logic                  end_of_file,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [KIND_W-1:0]     item_kind,
	output logic [BYTE_W-1:0]     out_char,
	output logic [LINE_NUM_W-1:0] line_number
);

	cslf_cfg_t cfg_q;
	logic      push_valid;
	logic      push_ready;
	cslf_op_t  push_data;
	logic      pop_valid;
	logic      pop_ready;
	cslf_op_t  pop_data;

	assign cfg_ready = 1'b1;

	// marker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_cmt  <= RST_LINE_COMMENT;
			cfg_q.blk_open  <= RST_BLOCK_OPEN;
			cfg_q.blk_close <= RST_BLOCK_CLOSE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LINE_COMMENT: cfg_q.line_cmt  <= cfg_data;
				REG_BLOCK_OPEN:   cfg_q.blk_open  <= cfg_data;
				REG_BLOCK_CLOSE:  cfg_q.blk_close <= cfg_data;
				default: ;
			endcase
		end
	end

	// classifier
	cslf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_file (end_of_file),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	// decoupling queue
	cslf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// comment state machine and output register
	cslf_back #(
		.NEST_LIMIT      (NEST_LIMIT),
		.LINE_COUNT_BITS (LINE_COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.item_kind   (item_kind),
		.out_char    (out_char),
		.line_number (line_number)
	);

endmodule

// ----- hdl/cslf_checker.sv -----
// Port-level checks for the comment-stripping line filter, bound to the top level.
// Depends on cslf_pkg and comment_stripping_line_filter_core.
module cslf_checker import cslf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [KIND_W-1:0]     item_kind,
	input logic [BYTE_W-1:0]     out_char,
	input logic [LINE_NUM_W-1:0] line_number
);

	// only the three defined result kinds are produced
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (item_kind == KIND_CHAR || item_kind == KIND_LINE ||
			item_kind == KIND_ERROR))
		else $error("illegal result kind");

	// line ends and errors carry no character
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != KIND_CHAR |-> out_char == '0)
		else $error("non-character result with nonzero character");

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(item_kind) && $stable(out_char) &&
			$stable(line_number))
		else $error("result payload changed under stall");

endmodule

bind comment_stripping_line_filter_core cslf_checker u_cslf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.item_kind   (item_kind),
	.out_char    (out_char),
	.line_number (line_number)
);

// ----- tb/sv/tb_comment_stripping_line_filter_core.sv -----
// Self-checking bench for comment_stripping_line_filter_core: directed table, then random text
// checked word by word against a behavioral copy of the filter under several marker settings.
// Depends on cslf_pkg and the comment_stripping_line_filter_core RTL.
module tb_comment_stripping_line_filter_core;
	import cslf_pkg::*;

	localparam int NEST_LIMIT       = 255;
	localparam int LINE_COUNT_BITS  = 24;
	localparam int SETTLE_CYCLES    = 16;
	localparam int CYCLE_LIMIT      = 1000000;
	localparam int RANDOM_PER_PHASE = 200;
	localparam int PHASES           = 5;
	localparam int DEEP_OPENS       = 300;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one result word of the filter
	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [BYTE_W-1:0]     ch;
		logic [LINE_NUM_W-1:0] line;
	} strip_item_t;

	localparam strip_item_t NO_ITEM = '0;

	// directed row: input word, and the result where it is typed in
	typedef struct {
		logic [BYTE_W-1:0] b;
		logic              eof;
		bit                typed;
		strip_item_t       item;
	} stim_row_t;

	localparam int DIR_ROWS = 24;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [BYTE_W-1:0]     cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [BYTE_W-1:0]     in_byte     = '0;
	logic                  end_of_file = 1'b0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [KIND_W-1:0]     item_kind;
	logic [BYTE_W-1:0]     out_char;
	logic [LINE_NUM_W-1:0] line_number;

	// typed result riding along with the payload
	bit                    row_typed   = 1'b0;
	strip_item_t           row_item    = '0;

	// behavioral copy of markers and filter state
	logic [BYTE_W-1:0]          mk_line  = RST_LINE_COMMENT;
	logic [BYTE_W-1:0]          mk_open  = RST_BLOCK_OPEN;
	logic [BYTE_W-1:0]          mk_close = RST_BLOCK_CLOSE;
	int                         nest_level  = 0;
	bit                         in_line_cmt = 1'b0;
	bit                         text_seen   = 1'b0;
	logic [LINE_COUNT_BITS-1:0] line_cnt    = '0;

	strip_item_t filtered_items[$];

	int  error_count     = 0;
	int  words_sent      = 0;
	int  results_checked = 0;
	int  unterminated    = 0;
	int  cycle_count     = 0;
	int  stall_hold      = 0;
	bit  no_idle         = 1'b0;

	stim_row_t dir_rows [DIR_ROWS] = '{
		'{8'h41, 1'b0, 1'b1, {KIND_CHAR, 8'h41, 24'd0}},
		'{8'h00, 1'b0, 1'b1, {KIND_CHAR, 8'h00, 24'd0}},
		'{8'hFF, 1'b0, 1'b1, {KIND_CHAR, 8'hFF, 24'd0}},
		'{NEWLINE_BYTE, 1'b0, 1'b1, {KIND_LINE, 8'h00, 24'd1}},
		'{NEWLINE_BYTE, 1'b0, 1'b0, NO_ITEM},
		'{RST_LINE_COMMENT, 1'b0, 1'b0, NO_ITEM},
		'{8'h78, 1'b0, 1'b0, NO_ITEM},
		'{RST_BLOCK_OPEN, 1'b0, 1'b0, NO_ITEM},
		'{NEWLINE_BYTE, 1'b0, 1'b0, NO_ITEM},
		'{8'h62, 1'b0, 1'b0, NO_ITEM},
		'{RST_BLOCK_OPEN, 1'b0, 1'b0, NO_ITEM},
		'{RST_BLOCK_OPEN, 1'b0, 1'b0, NO_ITEM},
		'{NEWLINE_BYTE, 1'b0, 1'b0, NO_ITEM},
		'{RST_BLOCK_CLOSE, 1'b0, 1'b0, NO_ITEM},
		'{8'h71, 1'b0, 1'b0, NO_ITEM},
		'{RST_BLOCK_CLOSE, 1'b0, 1'b0, NO_ITEM},
		'{RST_BLOCK_CLOSE, 1'b0, 1'b0, NO_ITEM},
		'{8'h63, 1'b0, 1'b0, NO_ITEM},
		'{8'hAA, 1'b1, 1'b0, NO_ITEM},
		'{8'h55, 1'b1, 1'b0, NO_ITEM},
		'{RST_BLOCK_OPEN, 1'b0, 1'b0, NO_ITEM},
		'{8'hFF, 1'b1, 1'b1, {KIND_ERROR, 8'h00, 24'd7}},
		'{8'h64, 1'b0, 1'b0, NO_ITEM},
		'{8'h00, 1'b1, 1'b0, NO_ITEM}
	};

	// marker settings per phase: line comment, block open, block close
	logic [BYTE_W-1:0] phase_marks [PHASES][3] = '{
		'{RST_LINE_COMMENT, RST_BLOCK_OPEN, RST_BLOCK_CLOSE},
		'{8'd47, 8'd40, 8'd41},
		'{8'd0, 8'd255, 8'd128},
		'{8'd255, 8'd42, 8'd42},
		'{NEWLINE_BYTE, 8'd0, NEWLINE_BYTE}
	};

	comment_stripping_line_filter_core #(
		.NEST_LIMIT      (NEST_LIMIT),
		.LINE_COUNT_BITS (LINE_COUNT_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_file (end_of_file),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.item_kind   (item_kind),
		.out_char    (out_char),
		.line_number (line_number)
	);

	always #6 clk = ~clk;

	// saturating line count
	function automatic void bump_line();
		if (line_cnt != '1)
			line_cnt = line_cnt + 1'b1;
	endfunction

	// newline or end of file outside a block: report the line if it kept text
	function automatic bit close_line(output strip_item_t item);
		bump_line();
		in_line_cmt = 1'b0;
		item = NO_ITEM;
		if (text_seen) begin
			text_seen = 1'b0;
			item.kind = KIND_LINE;
			item.line = line_cnt[LINE_NUM_W-1:0];
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// advance the filter by one input word; returns 1 when a result is produced
	function automatic bit strip_step(input logic [BYTE_W-1:0] b, input logic eof,
			output strip_item_t item);
		bit produced;
		produced = 1'b0;
		item = NO_ITEM;
		if (eof) begin
			if (nest_level != 0) begin
				bump_line();
				item.kind = KIND_ERROR;
				item.line = line_cnt[LINE_NUM_W-1:0];
				produced = 1'b1;
			end else begin
				produced = close_line(item);
			end
			nest_level = 0;
			in_line_cmt = 1'b0;
			text_seen = 1'b0;
		end else if (nest_level != 0) begin
			// inside a block: count newlines, close wins over open
			if (b == NEWLINE_BYTE)
				bump_line();
			if (b == mk_close)
				nest_level--;
			else if (b == mk_open && nest_level < NEST_LIMIT)
				nest_level++;
		end else if (b == NEWLINE_BYTE) begin
			produced = close_line(item);
		end else if (!in_line_cmt) begin
			if (b == mk_line) begin
				in_line_cmt = 1'b1;
			end else if (b == mk_open) begin
				nest_level = 1;
			end else if (b != mk_close) begin
				text_seen = 1'b1;
				item.kind = KIND_CHAR;
				item.ch = b;
				item.line = line_cnt[LINE_NUM_W-1:0];
				produced = 1'b1;
			end
		end
		return produced;
	endfunction

	// gap length: mostly none or short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// output stall pattern
	always @(negedge clk) begin : out_stall_gen
		int n;
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else if (!out_stall && !no_idle) begin
			n = idle_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				stall_hold <= n - 1;
			end
		end else begin
			out_stall <= 1'b0;
			stall_hold <= $urandom_range(0, 6);
		end
	end

	// sample accepted words on both channels, predict and check
	always @(posedge clk) begin : word_monitor
		strip_item_t predicted;
		strip_item_t head;
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("comment_stripping_line_filter_core test failed");
			$finish;
		end else if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_LINE_COMMENT: mk_line = cfg_data;
					REG_BLOCK_OPEN:   mk_open = cfg_data;
					REG_BLOCK_CLOSE:  mk_close = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				words_sent++;
				if (strip_step(in_byte, end_of_file, predicted))
					filtered_items.push_back(row_typed ? row_item : predicted);
			end
			if (out_valid && !out_stall) begin
				if (filtered_items.size() == 0) begin
					$error("result with nothing pending: item_kind %0d out_char %0h line_number %0d",
						item_kind, out_char, line_number);
					error_count++;
				end else begin
					head = filtered_items.pop_front();
					results_checked++;
					if (head.kind == KIND_ERROR)
						unterminated++;
					if (item_kind !== head.kind) begin
						$error("item_kind: expected %0d, got %0d", head.kind, item_kind);
						error_count++;
					end
					if (out_char !== head.ch) begin
						$error("out_char: expected %0h, got %0h", head.ch, out_char);
						error_count++;
					end
					if (line_number !== head.line) begin
						$error("line_number: expected %0d, got %0d", head.line, line_number);
						error_count++;
					end
				end
			end
		end
	end

	// drive one input word after a random gap; hold_off waits for all results first
	task automatic send_word(input logic [BYTE_W-1:0] b, input logic eof, input bit hold_off,
			input bit typed, input strip_item_t item);
		int gap;
		gap = no_idle ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0 || hold_off) begin
			in_valid <= 1'b0;
			repeat (gap == 0 ? 1 : gap) @(negedge clk);
			while (hold_off && filtered_items.size() != 0)
				@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_file <= eof;
		row_typed <= typed;
		row_item <= item;
		do @(posedge clk); while (in_stall);
	endtask

	// wait until every result is in, then let the pipeline empty
	task automatic wait_drained();
		while (filtered_items.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [BYTE_W-1:0] b;
		logic              eof;
		int                r;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				// directed rows under reset markers
				for (int i = 0; i < DIR_ROWS; i++)
					send_word(dir_rows[i].b, dir_rows[i].eof, 1'b0, dir_rows[i].typed,
						dir_rows[i].item);
			end else begin
				@(negedge clk);
				in_valid <= 1'b0;
				wait_drained();
				write_reg(REG_LINE_COMMENT, phase_marks[ph][0]);
				write_reg(REG_BLOCK_OPEN, phase_marks[ph][1]);
				write_reg(REG_BLOCK_CLOSE, phase_marks[ph][2]);
				// index past the last register must be dropped
				if (ph == 2)
					write_reg(REG_UNUSED, 8'h5A);
			end

			// nest past the depth limit, unwind, then show top level is back
			if (ph == 1) begin
				for (int i = 0; i < DEEP_OPENS; i++)
					send_word((i % 50 == 25) ? NEWLINE_BYTE : mk_open, 1'b0, 1'b0, 1'b0, NO_ITEM);
				for (int i = 0; i < NEST_LIMIT; i++)
					send_word(mk_close, 1'b0, 1'b0, 1'b0, NO_ITEM);
				send_word(8'h5A, 1'b0, 1'b0, 1'b0, NO_ITEM);
			end

			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if (i % 64 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				b = BYTE_W'($urandom_range(0, 255));
				eof = 1'b0;
				if (r >= 50 && r < 65)
					b = NEWLINE_BYTE;
				else if (r >= 65 && r < 72)
					b = mk_line;
				else if (r >= 72 && r < 83)
					b = mk_open;
				else if (r >= 83 && r < 94)
					b = mk_close;
				else if (r >= 94 && r < 97)
					eof = 1'b1;
				send_word(b, eof, (i % 97 == 96), 1'b0, NO_ITEM);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		$display("%0d words over %0d marker settings, %0d results checked", words_sent,
			PHASES, results_checked);
		$display("%0d unterminated block comment reports, final line count %0d", unterminated,
			line_cnt);
		if (error_count == 0)
			$display("comment_stripping_line_filter_core test passed");
		else
			$display("comment_stripping_line_filter_core test failed");
		$finish;
	end

endmodule
